[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file tgc_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define TGC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define TGC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/tgc_pkg.sv]
// ----------------------------------------------------------------------------
// tgc_pkg
// types, register codes and gesture codes of the touch gesture classifier
// ----------------------------------------------------------------------------
package tgc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TIME_W     = 32;
	localparam int POS_W      = 12;

	typedef logic [2:0] gesture_t;

	localparam gesture_t GEST_LONG   = 3'd0;
	localparam gesture_t GEST_UP     = 3'd1;
	localparam gesture_t GEST_DOWN   = 3'd2;
	localparam gesture_t GEST_LEFT   = 3'd3;
	localparam gesture_t GEST_RIGHT  = 3'd4;
	localparam gesture_t GEST_DOUBLE = 3'd5;
	localparam gesture_t GEST_PRESS  = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SWIPE_RATIO     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP      = 3'd4;

	localparam logic [15:0]      RST_POLL_INTERVAL = 16'd20;
	localparam logic [15:0]      RST_LONG_PRESS    = 16'd600;
	localparam logic [POS_W-1:0] RST_SWIPE_MIN     = 12'd40;
	localparam logic [7:0]       RST_SWIPE_RATIO   = 8'd8;
	localparam logic [15:0]      RST_DOUBLE_TAP    = 16'd300;

	typedef struct packed {
		logic [15:0]      poll_interval_ms;
		logic [15:0]      long_press_ms;
		logic [POS_W-1:0] swipe_min_travel;
		logic [7:0]       swipe_off_ratio_q4;
		logic [15:0]      double_tap_ms;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              finger_down;
		logic              pos_valid;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
	} sample_t;

	typedef struct packed {
		logic     valid;
		gesture_t gesture;
	} result_t;

endpackage

[src/touch_gesture_classifier_unit.sv]
// ----------------------------------------------------------------------------
// touch_gesture_classifier_unit
// touch sample in, at most one gesture event out (tap, double tap, long press,
// four swipe directions)
// ----------------------------------------------------------------------------
// One sample request is taken every clock while in_stall is low. A sample is
// registered on acceptance and classified from the input register, so its
// gesture, if any, is loaded into the output register once that can advance.
// The only limit on rate is the output register: while it holds an event and
// the consumer stalls, the sample waiting in the input register cannot move
// on and in_stall rises. Registers are written through cfg_we/cfg_index/
// cfg_data and must only change while no sample is in flight.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tgc_pkg::TIME_W-1:0]        now_ms,
	input  logic                              finger_down,
	input  logic                              pos_valid,
	input  logic [tgc_pkg::POS_W-1:0]         pos_x,
	input  logic [tgc_pkg::POS_W-1:0]         pos_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output tgc_pkg::gesture_t                 gesture
);
	import tgc_pkg::*;

	cfg_t     cfg_q;
	sample_t  smp_s1;
	logic     vld_s1;
	logic     out_valid_q;
	gesture_t gesture_q;
	logic     advance, accept;
	result_t  res;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_interval_ms   <= RST_POLL_INTERVAL;
			cfg_q.long_press_ms      <= RST_LONG_PRESS;
			cfg_q.swipe_min_travel   <= RST_SWIPE_MIN;
			cfg_q.swipe_off_ratio_q4 <= RST_SWIPE_RATIO;
			cfg_q.double_tap_ms      <= RST_DOUBLE_TAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLL_INTERVAL: cfg_q.poll_interval_ms   <= cfg_data;
				REG_LONG_PRESS:    cfg_q.long_press_ms      <= cfg_data;
				REG_SWIPE_MIN:     cfg_q.swipe_min_travel   <= cfg_data[POS_W-1:0];
				REG_SWIPE_RATIO:   cfg_q.swipe_off_ratio_q4 <= cfg_data[7:0];
				REG_DOUBLE_TAP:    cfg_q.double_tap_ms      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = vld_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1.now_ms      <= now_ms;
			smp_s1.finger_down <= finger_down;
			smp_s1.pos_valid   <= pos_valid;
			smp_s1.pos_x       <= pos_x;
			smp_s1.pos_y       <= pos_y;
		end
	end

	tgc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.smp    (smp_s1),
		.en     (vld_s1 && advance),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= vld_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_q <= res.gesture;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;

endmodule

[src/tgc_swipe_chk.sv]
// ----------------------------------------------------------------------------
// tgc_swipe_chk
// swipe test on one axis: enough on-axis travel and a small off-axis ratio
// ----------------------------------------------------------------------------
module tgc_swipe_chk (
	input  logic [tgc_pkg::POS_W-1:0] on_travel,
	input  logic [tgc_pkg::POS_W-1:0] off_travel,
	input  logic [tgc_pkg::POS_W-1:0] min_travel,
	input  logic [7:0]                ratio_q4,
	output logic                      hit
);
	import tgc_pkg::*;

	logic [POS_W+7:0] on_scaled;
	logic [POS_W+7:0] off_scaled;

	assign on_scaled  = on_travel * ratio_q4;
	assign off_scaled = {4'b0, off_travel, 4'b0};
	assign hit        = (on_travel >= min_travel) && (off_scaled <= on_scaled);

endmodule

[src/tgc_core.sv]
// ----------------------------------------------------------------------------
// tgc_core
// press state and gesture decision for one registered sample
// ----------------------------------------------------------------------------
module tgc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  tgc_pkg::cfg_t    cfg,
	input  tgc_pkg::sample_t smp,
	input  logic             en,
	output tgc_pkg::result_t res
);
	import tgc_pkg::*;

	logic              was_down_q, long_fired_q, tap_pending_q, start_valid_q;
	logic [TIME_W-1:0] press_start_q, last_sample_q, tap_end_q;
	logic [POS_W-1:0]  start_x_q, start_y_q, recent_x_q, recent_y_q;

	logic              was_down_n, long_fired_n, tap_pending_n, start_valid_n;
	logic [TIME_W-1:0] press_start_n, last_sample_n, tap_end_n;
	logic [POS_W-1:0]  start_x_n, start_y_n, recent_x_n, recent_y_n;

	logic [TIME_W-1:0] dt_last, dt_hold, dt_tap, dt_tap_n;
	logic [POS_W-1:0]  adx, ady;
	logic              vert_hit, horiz_hit, ok;
	logic              ev_valid;
	gesture_t          ev;

	assign dt_last = smp.now_ms - last_sample_q;
	assign dt_hold = smp.now_ms - press_start_q;
	assign dt_tap  = smp.now_ms - tap_end_q;
	assign adx     = (recent_x_q >= start_x_q) ? recent_x_q - start_x_q
	                                           : start_x_q - recent_x_q;
	assign ady     = (recent_y_q >= start_y_q) ? recent_y_q - start_y_q
	                                           : start_y_q - recent_y_q;
	assign ok      = !long_fired_q && start_valid_q;

	tgc_swipe_chk u_vert (
		.on_travel  (ady),
		.off_travel (adx),
		.min_travel (cfg.swipe_min_travel),
		.ratio_q4   (cfg.swipe_off_ratio_q4),
		.hit        (vert_hit)
	);

	tgc_swipe_chk u_horiz (
		.on_travel  (adx),
		.off_travel (ady),
		.min_travel (cfg.swipe_min_travel),
		.ratio_q4   (cfg.swipe_off_ratio_q4),
		.hit        (horiz_hit)
	);

	always_comb begin
		was_down_n    = was_down_q;
		long_fired_n  = long_fired_q;
		tap_pending_n = tap_pending_q;
		start_valid_n = start_valid_q;
		press_start_n = press_start_q;
		last_sample_n = last_sample_q;
		tap_end_n     = tap_end_q;
		start_x_n     = start_x_q;
		start_y_n     = start_y_q;
		recent_x_n    = recent_x_q;
		recent_y_n    = recent_y_q;
		ev_valid      = 1'b0;
		ev            = GEST_LONG;
		dt_tap_n      = dt_tap;
		if (dt_last >= {16'b0, cfg.poll_interval_ms}) begin
			last_sample_n = smp.now_ms;
			if (smp.finger_down && !was_down_q) begin
				was_down_n    = 1'b1;
				press_start_n = smp.now_ms;
				long_fired_n  = 1'b0;
				if (smp.pos_valid) begin
					recent_x_n    = smp.pos_x;
					recent_y_n    = smp.pos_y;
					start_x_n     = smp.pos_x;
					start_y_n     = smp.pos_y;
					start_valid_n = 1'b1;
				end
			end else if (smp.finger_down && was_down_q) begin
				if (smp.pos_valid) begin
					recent_x_n = smp.pos_x;
					recent_y_n = smp.pos_y;
				end
				if (!long_fired_q && dt_hold >= {16'b0, cfg.long_press_ms}) begin
					long_fired_n  = 1'b1;
					tap_pending_n = 1'b0;
					ev            = GEST_LONG;
					ev_valid      = 1'b1;
				end
			end else if (!smp.finger_down && was_down_q) begin
				was_down_n    = 1'b0;
				start_valid_n = 1'b0;
				if (long_fired_q) begin
					ev_valid = 1'b0;
				end else if (ok && vert_hit) begin
					ev            = (recent_y_q < start_y_q) ? GEST_UP : GEST_DOWN;
					ev_valid      = 1'b1;
					tap_pending_n = 1'b0;
				end else if (ok && horiz_hit) begin
					ev            = (recent_x_q < start_x_q) ? GEST_LEFT : GEST_RIGHT;
					ev_valid      = 1'b1;
					tap_pending_n = 1'b0;
				end else if (tap_pending_q && dt_tap < {16'b0, cfg.double_tap_ms}) begin
					ev            = GEST_DOUBLE;
					ev_valid      = 1'b1;
					tap_pending_n = 1'b0;
				end else begin
					tap_pending_n = 1'b1;
					tap_end_n     = smp.now_ms;
				end
			end
			dt_tap_n = smp.now_ms - tap_end_n;
			// pending tap times out into a plain press
			if (tap_pending_n && !was_down_n && dt_tap_n >= {16'b0, cfg.double_tap_ms}) begin
				tap_pending_n = 1'b0;
				if (!ev_valid) begin
					ev       = GEST_PRESS;
					ev_valid = 1'b1;
				end
			end
		end
	end

	assign res.valid   = ev_valid;
	assign res.gesture = ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_down_q    <= 1'b0;
			long_fired_q  <= 1'b0;
			tap_pending_q <= 1'b0;
			start_valid_q <= 1'b0;
			press_start_q <= '0;
			last_sample_q <= '0;
			tap_end_q     <= '0;
			start_x_q     <= '0;
			start_y_q     <= '0;
			recent_x_q    <= '0;
			recent_y_q    <= '0;
		end else if (en) begin
			was_down_q    <= was_down_n;
			long_fired_q  <= long_fired_n;
			tap_pending_q <= tap_pending_n;
			start_valid_q <= start_valid_n;
			press_start_q <= press_start_n;
			last_sample_q <= last_sample_n;
			tap_end_q     <= tap_end_n;
			start_x_q     <= start_x_n;
			start_y_q     <= start_y_n;
			recent_x_q    <= recent_x_n;
			recent_y_q    <= recent_y_n;
		end
	end

endmodule

[src/tgc_checker.sv]
// ----------------------------------------------------------------------------
// tgc_checker
// port-level checks on the touch gesture classifier
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgc_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_stall,
	input  logic              out_valid,
	input  logic              out_stall,
	input  tgc_pkg::gesture_t gesture
);
	import tgc_pkg::*;

	// an event on the output never carries an unused code
	`TGC_ASSERT_IMP(a_gesture_code, out_valid, gesture <= GEST_PRESS, "gesture code out of range")

	// a stalled event holds
	`TGC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(gesture), "stalled event changed")

	// input side only backs up when the output register is full and stalled
	`TGC_ASSERT_IMP(a_no_false_stall, !out_valid || !out_stall, !in_stall, "input stalled with output free")

	// a backed-up input persists until the output drains
	`TGC_ASSERT_NXT(a_stall_persist, in_stall, out_valid && (in_stall || !out_stall), "input stall dropped while output stalled")

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.gesture   (gesture)
);
